// ===== rtl/lsl_pkg.sv =====
package lsl_pkg;

	localparam int unsigned ChW = 8;
	localparam int unsigned NumW = 2 * ChW;
	localparam int unsigned DivStages = 4;
	localparam int unsigned StepsPerStage = ChW / DivStages;
	localparam int unsigned DivLat = DivStages + 1;

	typedef enum logic [1:0] {
		REG_SAT_THR = 2'd0,
		REG_OFFSET  = 2'd1,
		REG_SPAN    = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [3*ChW-1:0] pix;
		logic             keep;
		logic             zero;
		logic [ChW-1:0]   target;
	} side_t;

	typedef struct packed {
		side_t          side;
		logic [ChW-1:0] light;
	} front_t;

endpackage

// ===== rtl/low_saturation_lightness_flip.sv =====
// Low-saturation lightness flip. One 24-bit RGB pixel per request, one result per
// request, a new request may come on every clock (busy is always low). The result
// appears on pixel_out / kept_unchanged for exactly one cycle with done high, after
// these stages in order: four stages find lightness, the saturation test and
// the target level, one stage forms the channel products, five stages run the three
// channel dividers (an entry stage, then two quotient bits per stage), and one output register. The
// receiver cannot stall, so the pipeline simply advances every cycle. Write the
// cfg registers only while no request is in flight.
module low_saturation_lightness_flip (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [23:0] pixel_in,
	output logic        done,
	output logic [23:0] pixel_out,
	output logic        kept_unchanged,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata
);
	import lsl_pkg::*;

	// configuration registers
	logic [ChW-1:0] sat_thr_q, offset_q, span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_thr_q <= ChW'(40);
			offset_q <= ChW'(229);
			span_q <= ChW'(199);
		end else if (cfg_we) begin
			// unused index falls through and is ignored
			unique case (cfg_addr)
				REG_SAT_THR: sat_thr_q <= cfg_wdata;
				REG_OFFSET:  offset_q <= cfg_wdata;
				REG_SPAN:    span_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// nothing stalls the pipe
	assign busy = 1'b0;

	logic   front_valid;
	front_t front;

	lsl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.pixel_in (pixel_in),
		.sat_thr  (sat_thr_q),
		.offset   (offset_q),
		.span     (span_q),
		.out_valid(front_valid),
		.out_data (front)
	);

	// stage 5: channel times target; a zero-lightness pixel divides by one, result is overridden
	logic            v_s5;
	side_t           side_s5;
	logic [ChW-1:0]  light_s5;
	logic [NumW-1:0] prod_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= front_valid;
		end
	end
	always_ff @(posedge clk) begin
		side_s5 <= front.side;
		light_s5 <= front.side.zero ? ChW'(1) : front.light;
		for (int c = 0; c < 3; c++) begin
			prod_s5[c] <= NumW'(front.side.pix[c*ChW +: ChW]) * NumW'(front.side.target);
		end
	end

	// three divider lanes, blue in lane 0
	logic [ChW-1:0] quo [3];

	for (genvar c = 0; c < 3; c++) begin : g_lane
		lsl_div u_div (
			.clk(clk),
			.num(prod_s5[c]),
			.den(light_s5),
			.quo(quo[c])
		);
	end

	// sideband follows the divider latency
	logic  v_sd [DivLat];
	side_t side_sd [DivLat];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DivLat; i++) begin
				v_sd[i] <= 1'b0;
			end
		end else begin
			v_sd[0] <= v_s5;
			for (int i = 1; i < DivLat; i++) begin
				v_sd[i] <= v_sd[i-1];
			end
		end
	end
	always_ff @(posedge clk) begin
		side_sd[0] <= side_s5;
		for (int i = 1; i < DivLat; i++) begin
			side_sd[i] <= side_sd[i-1];
		end
	end

	// output register: passthrough, gray for zero lightness, else scaled channels
	side_t          side_last;
	logic [23:0]    result;
	logic           done_q, kept_q;
	logic [23:0]    pix_q;

	assign side_last = side_sd[DivLat-1];

	always_comb begin
		if (side_last.keep) begin
			result = side_last.pix;
		end else if (side_last.zero) begin
			result = {side_last.target, side_last.target, side_last.target};
		end else begin
			result = {quo[2], quo[1], quo[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_sd[DivLat-1];
		end
	end
	always_ff @(posedge clk) begin
		pix_q <= result;
		kept_q <= side_last.keep;
	end

	assign done = done_q;
	assign pixel_out = pix_q;
	assign kept_unchanged = kept_q;

	// every request comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##11 done)
		else $error("request lost in pipeline");

	// no result without a matching request
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 11))
		else $error("result without request");

	// passthrough returns the original pixel
	a_keep_pix: assert property (@(posedge clk) disable iff (!arst_n)
		(done && kept_unchanged) |-> (pixel_out == $past(pixel_in, 11)))
		else $error("kept pixel altered");
endmodule

// ===== rtl/lsl_front.sv =====
module lsl_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [3*lsl_pkg::ChW-1:0]   pixel_in,
	input  logic [lsl_pkg::ChW-1:0]     sat_thr,
	input  logic [lsl_pkg::ChW-1:0]     offset,
	input  logic [lsl_pkg::ChW-1:0]     span,
	output logic                        out_valid,
	output lsl_pkg::front_t             out_data
);
	import lsl_pkg::*;

	logic [ChW-1:0] r, g, b, hi, lo, rg_hi, rg_lo;
	logic           v_s1, v_s2, v_s3, v_s4;
	logic [3*ChW-1:0] pix_s1, pix_s2, pix_s3;
	logic [ChW-1:0] hi_s1, lo_s1;
	logic [ChW:0]   sum;
	logic [ChW-1:0] den, dif_s2, den_s2, light_s2, light_s3;
	logic [NumW-1:0] sat_num_s3, drop_prod_s3;
	logic [NumW:0]  thr_prod_s3;
	logic [NumW:0]  drop_sum;
	logic [ChW-1:0] drop, target;
	front_t         front_s4;

	assign r = pixel_in[3*ChW-1:2*ChW];
	assign g = pixel_in[2*ChW-1:ChW];
	assign b = pixel_in[ChW-1:0];
	assign rg_hi = (r > g) ? r : g;
	assign rg_lo = (r < g) ? r : g;
	assign hi = (rg_hi > b) ? rg_hi : b;
	assign lo = (rg_lo < b) ? rg_lo : b;

	// stage 1: channel extremes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		pix_s1 <= pixel_in;
		hi_s1 <= hi;
		lo_s1 <= lo;
	end

	// stage 2: lightness and saturation denominator
	assign sum = {1'b0, hi_s1} + {1'b0, lo_s1};
	always_comb begin
		if (sum <= (ChW+1)'(255)) begin
			den = sum[ChW-1:0];
		end else begin
			den = ChW'((ChW+1)'(510) - sum);
		end
		if (den == '0) begin
			den = ChW'(1);
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		pix_s2 <= pix_s1;
		dif_s2 <= hi_s1 - lo_s1;
		den_s2 <= den;
		light_s2 <= sum[ChW:1];
	end

	// stage 3: products for the threshold test and the lightness drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		pix_s3 <= pix_s2;
		light_s3 <= light_s2;
		sat_num_s3 <= NumW'(dif_s2) * NumW'(255);
		thr_prod_s3 <= ((NumW+1)'(sat_thr) + (NumW+1)'(1)) * (NumW+1)'(den_s2);
		drop_prod_s3 <= NumW'(span) * NumW'(light_s2);
	end

	// stage 4: sat > thr is the same as dif*255 >= (thr+1)*den; x/255 by reciprocal
	assign drop_sum = (NumW+1)'(drop_prod_s3) + (NumW+1)'(1)
		+ (NumW+1)'(drop_prod_s3 >> ChW);
	assign drop = drop_sum[2*ChW-1:ChW];
	assign target = (drop > offset) ? '0 : offset - drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end
	always_ff @(posedge clk) begin
		front_s4.side.pix <= pix_s3;
		front_s4.side.keep <= ((NumW+1)'(sat_num_s3) >= thr_prod_s3);
		front_s4.side.zero <= (light_s3 == '0);
		front_s4.side.target <= target;
		front_s4.light <= light_s3;
	end

	assign out_valid = v_s4;
	assign out_data = front_s4;
endmodule

// ===== rtl/lsl_div.sv =====
module lsl_div (
	input  logic                       clk,
	input  logic [lsl_pkg::NumW-1:0]   num,
	input  logic [lsl_pkg::ChW-1:0]    den,
	output logic [lsl_pkg::ChW-1:0]    quo
);
	import lsl_pkg::*;

	logic [NumW-1:0] rem_s [DivStages+1];
	logic [ChW-1:0]  quo_s [DivStages+1];
	logic [ChW-1:0]  den_s [DivStages+1];
	logic            ovf_s [DivStages+1];

	// entry stage: quotients past the channel range clamp, so flag them here
	always_ff @(posedge clk) begin
		rem_s[0] <= num;
		quo_s[0] <= '0;
		den_s[0] <= den;
		ovf_s[0] <= (num >= {den, ChW'(0)});
	end

	for (genvar s = 0; s < DivStages; s++) begin : g_stage
		logic [NumW-1:0] rem_n;
		logic [ChW-1:0]  quo_n;

		always_comb begin
			logic [NumW-1:0] shifted;
			rem_n = rem_s[s];
			quo_n = quo_s[s];
			for (int j = 0; j < StepsPerStage; j++) begin
				shifted = NumW'(den_s[s]) << (ChW - 1 - s * StepsPerStage - j);
				if (rem_n >= shifted) begin
					rem_n = rem_n - shifted;
					quo_n[ChW - 1 - s * StepsPerStage - j] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_s[s+1] <= rem_n;
			quo_s[s+1] <= quo_n;
			den_s[s+1] <= den_s[s];
			ovf_s[s+1] <= ovf_s[s];
		end
	end

	assign quo = ovf_s[DivStages] ? '1 : quo_s[DivStages];
endmodule

// ===== tb/tb_low_saturation_lightness_flip.sv =====
`timescale 1ns / 100ps

import lsl_pkg::*;

// scoreboard: predicts each pixel from a private copy of the registers and
// checks results in order
class flip_scoreboard;
	logic [7:0] thr, offs, span;
	logic [24:0] pending_pixels[$];
	int errors;

	function void reset_regs();
		thr = 8'd40;
		offs = 8'd229;
		span = 8'd199;
		pending_pixels.delete();
		errors = 0;
	endfunction

	function void write_reg(reg_idx_t idx, logic [7:0] val);
		case (idx)
			REG_SAT_THR: thr = val;
			REG_OFFSET: offs = val;
			REG_SPAN: span = val;
			default: ;
		endcase
	endfunction

	// returns {kept, pixel}
	function logic [24:0] flip_pixel(logic [23:0] px);
		int unsigned ch[3];
		int unsigned hi, lo, sum, light, denom, sat, drop, target, v;
		logic [23:0] res;
		ch[0] = 32'(px[23:16]);
		ch[1] = 32'(px[15:8]);
		ch[2] = 32'(px[7:0]);
		hi = ch[0];
		lo = ch[0];
		for (int i = 1; i < 3; i++) begin
			if (ch[i] > hi) hi = ch[i];
			if (ch[i] < lo) lo = ch[i];
		end
		sum = hi + lo;
		light = sum / 2;
		denom = (sum <= 255) ? sum : 510 - sum;
		if (denom == 0) denom = 1;
		sat = ((hi - lo) * 255) / denom;
		if (sat > thr) return {1'b1, px};
		drop = (span * light) / 255;
		target = (drop > offs) ? 0 : offs - drop;
		if (light == 0) return {1'b0, target[7:0], target[7:0], target[7:0]};
		for (int i = 0; i < 3; i++) begin
			v = (ch[i] * target) / light;
			if (v > 255) v = 255;
			res[23-8*i -: 8] = v[7:0];
		end
		return {1'b0, res};
	endfunction

	function void note_request(logic [23:0] px);
		pending_pixels.push_back(flip_pixel(px));
	endfunction

	function void report_mismatch(string msg);
		errors++;
		$display("mismatch at %0t: %s", $time, msg);
	endfunction

	function void check_result(logic [23:0] px, logic kept);
		logic [24:0] exp_res;
		if (pending_pixels.size() == 0) begin
			report_mismatch($sformatf("unexpected result %06h", px));
			return;
		end
		exp_res = pending_pixels.pop_front();
		if (px !== exp_res[23:0])
			report_mismatch($sformatf("pixel_out %06h, want %06h", px, exp_res[23:0]));
		if (kept !== exp_res[24])
			report_mismatch($sformatf("kept_unchanged %b, want %b", kept, exp_res[24]));
	endfunction
endclass

module tb_low_saturation_lightness_flip;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [23:0] pixel_in = '0;
	logic        done;
	logic [23:0] pixel_out;
	logic        kept_unchanged;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_addr = '0;
	logic [7:0]  cfg_wdata = '0;

	flip_scoreboard pixel_board;
	int idle_pct;   // chance in percent that the sender skips a cycle

	always #4 clk = ~clk;

	low_saturation_lightness_flip u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pixel_in(pixel_in), .done(done), .pixel_out(pixel_out),
		.kept_unchanged(kept_unchanged), .cfg_we(cfg_we),
		.cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	// results are sampled at the edge that ends their cycle
	always @(posedge clk) begin
		if (arst_n && done)
			pixel_board.check_result(pixel_out, kept_unchanged);
	end

	// one request: optional idle gaps, then hold start until the block takes it
	// start stays high afterwards so back to back requests need no gap
	task automatic send_pixel(logic [23:0] px);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		pixel_in <= px;
		do @(posedge clk); while (busy);
		pixel_board.note_request(px);
	endtask

	// wait for the pipeline to drain, plus slack for its latency
	task automatic drain();
		start <= 1'b0;
		while (pixel_board.pending_pixels.size() != 0) @(posedge clk);
		repeat (DivLat + 12) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		pixel_board.write_reg(idx, val);
		@(posedge clk);
	endtask

	// mostly low-saturation pixels so the flip path gets most traffic
	function automatic logic [23:0] rand_pixel();
		logic [7:0] base, r, g, b;
		int unsigned spread;
		if ($urandom_range(3) == 0) return 24'($urandom());
		base = 8'($urandom());
		spread = $urandom_range(24);
		r = 8'(base + $urandom_range(spread));
		g = 8'(base + $urandom_range(spread));
		b = 8'(base + $urandom_range(spread));
		if (r < base) r = 8'hff;
		if (g < base) g = 8'hff;
		if (b < base) b = 8'hff;
		return {r, g, b};
	endfunction

	initial begin
		logic [23:0] directed[$];
		pixel_board = new();
		pixel_board.reset_regs();
		idle_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// black, white, grays, pure primaries, near-gray, channel overflow cases
		directed = '{24'h000000, 24'hffffff, 24'h808080, 24'h010101, 24'hfefefe,
			24'hff0000, 24'h00ff00, 24'h0000ff, 24'h7f7f80, 24'h807f7f,
			24'h0a0b0c, 24'h020100, 24'h000001, 24'hfffffe, 24'h101418,
			24'hc8c8d0, 24'h5a5555, 24'haaaaaa, 24'h555555, 24'hf0f0f0};
		foreach (directed[i]) send_pixel(directed[i]);
		drain();

		// extreme settings: zero span, negative target via large span
		write_reg(REG_SAT_THR, 8'd255);
		write_reg(REG_OFFSET, 8'd255);
		write_reg(REG_SPAN, 8'd0);
		foreach (directed[i]) send_pixel(directed[i]);
		drain();
		write_reg(REG_OFFSET, 8'd0);
		write_reg(REG_SPAN, 8'd255);
		write_reg(REG_SAT_THR, 8'd0);
		foreach (directed[i]) send_pixel(directed[i]);
		drain();

		// random phases with different idling and register settings
		for (int phase = 0; phase < 8; phase++) begin
			case (phase % 3)
				0: idle_pct = 0;
				1: idle_pct = 80;
				default: idle_pct = 23;
			endcase
			write_reg(REG_SAT_THR, (phase == 7) ? 8'd255 : 8'($urandom_range(80)));
			write_reg(REG_OFFSET, (phase == 6) ? 8'd0 : 8'($urandom()));
			write_reg(REG_SPAN, (phase == 5) ? 8'd255 : 8'($urandom()));
			for (int n = 0; n < 225; n++) send_pixel(rand_pixel());
			drain();
		end

		if (pixel_board.errors == 0)
			$display("low_saturation_lightness_flip verification clean");
		else
			$display("low_saturation_lightness_flip verification failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("low_saturation_lightness_flip verification failed");
		$finish;
	end

endmodule
